// ----- hdl/gyib_pkg.sv -----
// shared types, codes and constants of the gyro yaw integrator
package gyib_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MEAN_UPD,
    ST_STILL,
    ST_THR,
    ST_BIAS,
    ST_CLAMP,
    ST_CORR,
    ST_SCALE,
    ST_PLO,
    ST_PHI,
    ST_PSUM,
    ST_DIV,
    ST_HEAD,
    ST_DONE
  } state_e;

  // request codes
  localparam logic REQ_SAMPLE       = 1'b0;
  localparam logic REQ_ZERO_HEADING = 1'b1;

  // config register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_ALPHA       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_BAND       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_RATE_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STILL_TIME_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_FAST_ALPHA  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_SLOW_ALPHA  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_LIMIT       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN        = 3'd7;

  typedef struct packed {
    logic [15:0] mean_alpha;
    logic [30:0] still_band;
    logic [30:0] still_rate_limit;
    logic [23:0] still_time_limit;
    logic [15:0] bias_fast_alpha;
    logic [15:0] bias_slow_alpha;
    logic [30:0] bias_limit;
    logic [19:0] rate_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mean_alpha:       16'd3277,
    still_band:       31'd65536,
    still_rate_limit: 31'd327680,
    still_time_limit: 24'd128000,
    bias_fast_alpha:  16'd6554,
    bias_slow_alpha:  16'd66,
    bias_limit:       31'd327680,
    rate_gain:        20'd65536
  };

  // shared multiplier
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // divide by 125 after the shift by 11 (256000 = 2^11 * 125)
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = 13;
  localparam int DIV_W          = DIV_RADIX_BITS * DIV_STEPS;
  localparam int DIV_REM_W      = 7;
  localparam logic [DIV_REM_W:0] DIV_DIVISOR = 8'd125;

  // heading saturation bounds, sign-extended to the adder width
  localparam int HSUM_W = 52;
  localparam logic signed [HSUM_W-1:0] HEAD_SAT_MAX = 52'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [HSUM_W-1:0] HEAD_SAT_MIN = 52'shF_8000_0000_0000;

  localparam logic [23:0] STILL_SAT = 24'hFF_FFFF;

endpackage

// ----- hdl/gyro_yaw_integrator_bias_track.sv -----
// gyro heading integrator with stillness detection and bias tracking
// a rate sample passes through the mean, stillness, bias (when the still time reaches its limit),
// correction, scaling and product states, the 13-step radix-16 divide by 125 and the passes
// through the one shared multiplier; a zero-step sample or a zero-heading request goes straight to done.
// one item at a time; the result sits in an output register until taken.
// reset clears the filter state and the result register and loads the register defaults.
module gyro_yaw_integrator_bias_track (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [23:0]                     step_ms_i,
  input  logic signed [31:0]              rate_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [47:0]              heading_o,
  output logic signed [31:0]              bias_estimate_o,
  output logic                            bias_settled_o,
  output logic                            is_still_o,
  input  logic                            cfg_we_i,
  input  logic [gyib_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gyib_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  gyib_pkg::cfg_t   cfg;
  gyib_pkg::state_e state_q, state_d;

  // state
  logic signed [31:0] mean_q, bias_q;
  logic [23:0]        still_q;
  logic               locked_q;
  logic signed [47:0] heading_q;

  // per-sample scratch
  logic signed [31:0] rate_q;
  logic [23:0]        step_q;
  logic [36:0]        mag_q;
  logic               neg_q;
  logic [60:0]        acc_q;

  logic out_valid_q;

  // control
  logic in_accept, out_load, thr, div_start, div_done;
  logic signed [gyib_pkg::MUL_A_W-1:0] mul_a;
  logic signed [gyib_pkg::MUL_B_W-1:0] mul_b;
  logic signed [gyib_pkg::PROD_W-1:0]  prod;
  logic [gyib_pkg::DIV_W-1:0]          div_quot, div_dividend;

  // datapath
  logic signed [32:0] diff_rm, diff_mb, diff_rb, mean_sum, bias_sum;
  logic [32:0]        dev_abs;
  logic [31:0]        mean_abs;
  logic [24:0]        still_sum;
  logic               still_smp;
  logic signed [31:0] lim_pos, lim_neg;
  logic [36:0]        scaled;
  logic [60:0]        psum;
  logic [gyib_pkg::HSUM_W-1:0] inc;
  logic signed [gyib_pkg::HSUM_W-1:0] hsum;

  gyib_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gyib_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  gyib_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  assign diff_rm  = {rate_q[31], rate_q} - {mean_q[31], mean_q};
  assign diff_mb  = {mean_q[31], mean_q} - {bias_q[31], bias_q};
  assign diff_rb  = {rate_q[31], rate_q} - {bias_q[31], bias_q};
  // floor of the product over 2^16 is its upper slice
  assign mean_sum = {mean_q[31], mean_q} + $signed(prod[48:16]);
  assign bias_sum = {bias_q[31], bias_q} + $signed(prod[48:16]);

  assign dev_abs   = diff_rm[32] ? (33'd0 - diff_rm) : diff_rm;
  assign mean_abs  = mean_q[31] ? (32'd0 - mean_q) : mean_q;
  assign still_smp = (dev_abs < {2'b00, cfg.still_band}) &&
                     (mean_abs < {1'b0, cfg.still_rate_limit});
  assign still_sum = {1'b0, still_q} + {1'b0, step_q};
  assign thr       = (still_q >= cfg.still_time_limit);

  assign lim_pos = $signed({1'b0, cfg.bias_limit});
  assign lim_neg = 32'sd0 - lim_pos;

  assign scaled = prod[52:16];
  // magnitude times step, low half already in acc_q
  assign psum   = acc_q + {prod[42:0], 18'd0};
  assign div_dividend = {2'b00, psum[60:11]};

  assign inc  = neg_q ? (gyib_pkg::HSUM_W'(0) - {2'b00, div_quot[49:0]})
                      : {2'b00, div_quot[49:0]};
  assign hsum = {{4{heading_q[47]}}, heading_q} + $signed(inc);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gyib_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == gyib_pkg::REQ_ZERO_HEADING || step_ms_i == '0) begin
            state_d = gyib_pkg::ST_DONE;
          end else begin
            state_d = gyib_pkg::ST_MEAN;
          end
        end
      end
      gyib_pkg::ST_MEAN:     state_d = gyib_pkg::ST_MEAN_UPD;
      gyib_pkg::ST_MEAN_UPD: state_d = gyib_pkg::ST_STILL;
      gyib_pkg::ST_STILL:    state_d = gyib_pkg::ST_THR;
      gyib_pkg::ST_THR:      state_d = thr ? gyib_pkg::ST_BIAS : gyib_pkg::ST_CORR;
      gyib_pkg::ST_BIAS:     state_d = gyib_pkg::ST_CLAMP;
      gyib_pkg::ST_CLAMP:    state_d = gyib_pkg::ST_CORR;
      gyib_pkg::ST_CORR:     state_d = gyib_pkg::ST_SCALE;
      gyib_pkg::ST_SCALE:    state_d = gyib_pkg::ST_PLO;
      gyib_pkg::ST_PLO:      state_d = gyib_pkg::ST_PHI;
      gyib_pkg::ST_PHI:      state_d = gyib_pkg::ST_PSUM;
      gyib_pkg::ST_PSUM:     state_d = gyib_pkg::ST_DIV;
      gyib_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = gyib_pkg::ST_HEAD;
        end
      end
      gyib_pkg::ST_HEAD:     state_d = gyib_pkg::ST_DONE;
      gyib_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = gyib_pkg::ST_IDLE;
        end
      end
      default:               state_d = gyib_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    div_start  = 1'b0;
    mul_a      = {diff_rm[32], diff_rm};
    mul_b      = {9'd0, cfg.mean_alpha};
    case (state_q)
      gyib_pkg::ST_IDLE: in_ready_o = 1'b1;
      gyib_pkg::ST_THR: begin
        mul_a = {diff_mb[32], diff_mb};
        mul_b = {9'd0, (locked_q ? cfg.bias_slow_alpha : cfg.bias_fast_alpha)};
      end
      gyib_pkg::ST_CORR: begin
        mul_a = {diff_rb[32], diff_rb};
        mul_b = {{5{cfg.rate_gain[19]}}, cfg.rate_gain};
      end
      gyib_pkg::ST_PLO: begin
        mul_a = {16'd0, mag_q[17:0]};
        mul_b = {1'b0, step_q};
      end
      gyib_pkg::ST_PHI: begin
        mul_a = {15'd0, mag_q[36:18]};
        mul_b = {1'b0, step_q};
      end
      gyib_pkg::ST_PSUM: div_start = 1'b1;
      gyib_pkg::ST_DONE: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gyib_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q    <= '0;
      still_q   <= '0;
      bias_q    <= '0;
      locked_q  <= 1'b0;
      heading_q <= '0;
    end else begin
      case (state_q)
        gyib_pkg::ST_IDLE: begin
          if (in_accept && req_type_i == gyib_pkg::REQ_ZERO_HEADING) begin
            heading_q <= '0;
          end
        end
        gyib_pkg::ST_MEAN_UPD: mean_q <= mean_sum[31:0];
        gyib_pkg::ST_STILL: begin
          if (!still_smp) begin
            still_q <= '0;
          end else if (still_sum[24]) begin
            still_q <= gyib_pkg::STILL_SAT;
          end else begin
            still_q <= still_sum[23:0];
          end
        end
        gyib_pkg::ST_BIAS: begin
          bias_q   <= bias_sum[31:0];
          locked_q <= 1'b1;
        end
        gyib_pkg::ST_CLAMP: begin
          if (bias_q > lim_pos) begin
            bias_q <= lim_pos;
          end else if (bias_q < lim_neg) begin
            bias_q <= lim_neg;
          end
        end
        gyib_pkg::ST_HEAD: begin
          if (hsum > gyib_pkg::HEAD_SAT_MAX) begin
            heading_q <= gyib_pkg::HEAD_SAT_MAX[47:0];
          end else if (hsum < gyib_pkg::HEAD_SAT_MIN) begin
            heading_q <= gyib_pkg::HEAD_SAT_MIN[47:0];
          end else begin
            heading_q <= hsum[47:0];
          end
        end
        default: ;
      endcase
    end
  end

  // scratch registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      gyib_pkg::ST_IDLE: begin
        if (in_accept) begin
          rate_q <= rate_sample_i;
          step_q <= step_ms_i;
        end
      end
      gyib_pkg::ST_SCALE: begin
        // truncation toward zero works on the magnitude
        mag_q <= scaled[36] ? (37'd0 - scaled) : scaled;
        neg_q <= scaled[36];
      end
      gyib_pkg::ST_PHI: acc_q <= {19'd0, prod[41:0]};
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q     <= 1'b0;
      heading_o       <= '0;
      bias_estimate_o <= '0;
      bias_settled_o  <= 1'b0;
      is_still_o      <= 1'b0;
    end else if (out_load) begin
      out_valid_q     <= 1'b1;
      heading_o       <= heading_q;
      bias_estimate_o <= bias_q;
      bias_settled_o  <= locked_q;
      is_still_o      <= thr;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/gyib_mul.sv -----
// shared signed multiplier with registered product
module gyib_mul (
  input  logic                                clk_i,
  input  logic signed [gyib_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [gyib_pkg::MUL_B_W-1:0] b_i,
  output logic signed [gyib_pkg::PROD_W-1:0]  prod_o
);

  logic signed [gyib_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- hdl/gyib_div.sv -----
// radix-16 long division by 125, four quotient bits per cycle
module gyib_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gyib_pkg::DIV_W-1:0]  dividend_i,
  output logic [gyib_pkg::DIV_W-1:0]  quot_o,
  output logic                        done_o
);

  localparam int DIV_CNT_W = $clog2(gyib_pkg::DIV_STEPS + 1);

  logic [DIV_CNT_W-1:0]              cnt_q;
  logic [gyib_pkg::DIV_W-1:0]        dvd_q, dvd_d;
  logic [gyib_pkg::DIV_REM_W-1:0]    rem_q, rem_d;
  logic                              busy;

  assign busy   = (cnt_q != '0);
  assign done_o = (cnt_q == DIV_CNT_W'(1));
  assign quot_o = dvd_q;

  always_comb begin : div_step
    logic [gyib_pkg::DIV_REM_W:0] trial;
    rem_d = rem_q;
    dvd_d = dvd_q;
    trial = '0;
    // quotient bits shift in at the bottom as dividend bits leave the top
    for (int i = 0; i < gyib_pkg::DIV_RADIX_BITS; i++) begin
      trial = {rem_d, dvd_d[gyib_pkg::DIV_W-1]};
      dvd_d = {dvd_d[gyib_pkg::DIV_W-2:0], 1'b0};
      if (trial >= gyib_pkg::DIV_DIVISOR) begin
        rem_d    = gyib_pkg::DIV_REM_W'(trial - gyib_pkg::DIV_DIVISOR);
        dvd_d[0] = 1'b1;
      end else begin
        rem_d = trial[gyib_pkg::DIV_REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIV_CNT_W'(gyib_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

endmodule

// ----- hdl/gyib_cfg.sv -----
// configuration register file
module gyib_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gyib_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gyib_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output gyib_pkg::cfg_t                    cfg_o
);

  gyib_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= gyib_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gyib_pkg::CFG_MEAN_ALPHA:       cfg_q.mean_alpha       <= cfg_wdata_i[15:0];
        gyib_pkg::CFG_STILL_BAND:       cfg_q.still_band       <= cfg_wdata_i[30:0];
        gyib_pkg::CFG_STILL_RATE_LIMIT: cfg_q.still_rate_limit <= cfg_wdata_i[30:0];
        gyib_pkg::CFG_STILL_TIME_LIMIT: cfg_q.still_time_limit <= cfg_wdata_i[23:0];
        gyib_pkg::CFG_BIAS_FAST_ALPHA:  cfg_q.bias_fast_alpha  <= cfg_wdata_i[15:0];
        gyib_pkg::CFG_BIAS_SLOW_ALPHA:  cfg_q.bias_slow_alpha  <= cfg_wdata_i[15:0];
        gyib_pkg::CFG_BIAS_LIMIT:       cfg_q.bias_limit       <= cfg_wdata_i[30:0];
        gyib_pkg::CFG_RATE_GAIN:        cfg_q.rate_gain        <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/gyib_checker.sv -----
// port-level checks of the gyro yaw integrator, bound to the top level
module gyib_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            req_type_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic signed [47:0]              heading_o,
  input logic signed [31:0]              bias_estimate_o,
  input logic                            bias_settled_o,
  input logic                            is_still_o
);

  // one item at a time: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // zero-heading request with a free result slot shows a zero heading once the done state loads the result
  a_zero_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i == gyib_pkg::REQ_ZERO_HEADING && !out_valid_o
    |-> ##2 (out_valid_o && heading_o == '0))
    else $error("zero-heading request did not clear the heading");

  // the lock flag never drops once set
  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(bias_settled_o))
    else $error("bias lock flag dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i
    |=> out_valid_o && $stable(heading_o) && $stable(bias_estimate_o) &&
        $stable(bias_settled_o) && $stable(is_still_o))
    else $error("stalled result beat changed");

endmodule

bind gyro_yaw_integrator_bias_track gyib_checker u_gyib_checker (.*);
